// File: src/des_pkg.sv
// shared types, codes and helpers for the drive enable sequencer
package des_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_STATUS_MASK      = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_CODE_READY       = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_CODE_SWITCHED_ON = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_CODE_OP_ENABLED  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_CODE_FAULT       = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_CODE_ON_DISABLED = 3'd5;

  localparam logic [15:0] RST_STATUS_MASK      = 16'h006F;
  localparam logic [15:0] RST_CODE_READY       = 16'h0021;
  localparam logic [15:0] RST_CODE_SWITCHED_ON = 16'h0023;
  localparam logic [15:0] RST_CODE_OP_ENABLED  = 16'h0027;
  localparam logic [15:0] RST_CODE_FAULT       = 16'h0008;
  localparam logic [15:0] RST_CODE_ON_DISABLED = 16'h0040;

  localparam logic [15:0] CW_NONE        = 16'd0;
  localparam logic [15:0] CW_SHUTDOWN    = 16'd6;
  localparam logic [15:0] CW_SWITCH_ON   = 16'd7;
  localparam logic [15:0] CW_ENABLE_OP   = 16'd15;
  localparam logic [15:0] CW_FAULT_RESET = 16'd128;
  localparam logic [15:0] CW_QUICK_STOP  = 16'd2;

  localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_CODE_SETUP    = 3'd1;
  localparam logic [2:0] MODE_CODE_SHUTDOWN = 3'd2;
  localparam logic [2:0] MODE_CODE_SWON     = 3'd3;
  localparam logic [2:0] MODE_CODE_ENABLE   = 3'd4;
  localparam logic [2:0] MODE_CODE_RUNNING  = 3'd5;
  localparam logic [2:0] MODE_CODE_FAULT    = 3'd6;

  typedef enum logic [2:0] {
    CMD_SYNC     = 3'd0,
    CMD_STATUS   = 3'd1,
    CMD_RUNNING  = 3'd2,
    CMD_STOPPED  = 3'd3,
    CMD_CONFIRM  = 3'd4,
    CMD_TARGET   = 3'd5
  } cmd_t;

  typedef enum logic [6:0] {
    MODE_IDLE     = 7'b0000001,
    MODE_SETUP    = 7'b0000010,
    MODE_SHUTDOWN = 7'b0000100,
    MODE_SWON     = 7'b0001000,
    MODE_ENABLE   = 7'b0010000,
    MODE_RUNNING  = 7'b0100000,
    MODE_FAULT    = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [15:0] status_mask;
    logic [15:0] code_ready;
    logic [15:0] code_switched_on;
    logic [15:0] code_op_enabled;
    logic [15:0] code_fault;
    logic [15:0] code_on_disabled;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic               write_sent;
    logic               write_done;
    logic               reset_sent;
    logic [15:0]        last_status;
    logic signed [31:0] last_position;
    logic signed [31:0] held_target;
  } seq_state_t;

  typedef struct packed {
    logic               cw_valid;
    logic [15:0]        control_out;
    logic               target_valid;
    logic signed [31:0] target_out;
    logic               mode_write_req;
    logic [2:0]         master_mode;
  } result_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    c = MODE_CODE_IDLE;
    unique case (m)
      MODE_IDLE:     c = MODE_CODE_IDLE;
      MODE_SETUP:    c = MODE_CODE_SETUP;
      MODE_SHUTDOWN: c = MODE_CODE_SHUTDOWN;
      MODE_SWON:     c = MODE_CODE_SWON;
      MODE_ENABLE:   c = MODE_CODE_ENABLE;
      MODE_RUNNING:  c = MODE_CODE_RUNNING;
      MODE_FAULT:    c = MODE_CODE_FAULT;
      default:       c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: src/drive_enable_sequencer.sv
// top level of the drive enable sequencer: input stage, sequencer state, result stage
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | command, status_in, position_in,
//          |           |                    | abort_code, target_in
//  out_    | output    | out_valid/out_stall| cw_valid, control_out, target_valid,
//          |           |                    | target_out, mode_write_req, master_mode
//  cfg_    | input     | cfg_we             | cfg_addr, cfg_wdata
//
// one item per cycle sustained while out_stall is low; each item passes through the input
// register, then the event update into the result register
// the rate is set by the update of the mode and state registers
// synchronous active-low reset returns mode to idle and configuration to defaults
// out_stall holds the result register; the input register then fills and in_stall rises
module drive_enable_sequencer
  import des_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [15:0]        in_status_in,
  input  logic signed [31:0] in_position_in,
  input  logic [31:0]        in_abort_code,
  input  logic signed [31:0] in_target_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_cw_valid,
  output logic [15:0]        out_control_out,
  output logic               out_target_valid,
  output logic signed [31:0] out_target_out,
  output logic               out_mode_write_req,
  output logic [2:0]         out_master_mode,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata
);

  cfg_t       cfg;
  seq_state_t state_r;
  seq_state_t state_nxt;
  result_t    step_res;
  result_t    res_r;

  logic               s1_valid_r;
  logic [2:0]         s1_command_r;
  logic [15:0]        s1_status_r;
  logic signed [31:0] s1_position_r;
  logic [31:0]        s1_abort_r;
  logic signed [31:0] s1_target_r;
  logic               out_valid_r;
  logic               advance;

  des_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  des_step u_step (
    .cfg         (cfg),
    .state       (state_r),
    .command     (s1_command_r),
    .status_in   (s1_status_r),
    .position_in (s1_position_r),
    .abort_code  (s1_abort_r),
    .target_in   (s1_target_r),
    .state_nxt   (state_nxt),
    .result      (step_res)
  );

  // result register free or draining this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_command_r  <= in_command;
      s1_status_r   <= in_status_in;
      s1_position_r <= in_position_in;
      s1_abort_r    <= in_abort_code;
      s1_target_r   <= in_target_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode          <= MODE_IDLE;
      state_r.write_sent    <= 1'b0;
      state_r.write_done    <= 1'b0;
      state_r.reset_sent    <= 1'b0;
      state_r.last_status   <= '0;
      state_r.last_position <= '0;
      state_r.held_target   <= '0;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) res_r <= step_res;
  end

  assign out_valid          = out_valid_r;
  assign out_cw_valid       = res_r.cw_valid;
  assign out_control_out    = res_r.control_out;
  assign out_target_valid   = res_r.target_valid;
  assign out_target_out     = res_r.target_out;
  assign out_mode_write_req = res_r.mode_write_req;
  assign out_master_mode    = res_r.master_mode;

endmodule

// File: src/des_cfg_regs.sv
// configuration register file with write decode
module des_cfg_regs
  import des_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_STATUS_MASK:      cfg_nxt.status_mask      = cfg_wdata;
        CFG_CODE_READY:       cfg_nxt.code_ready       = cfg_wdata;
        CFG_CODE_SWITCHED_ON: cfg_nxt.code_switched_on = cfg_wdata;
        CFG_CODE_OP_ENABLED:  cfg_nxt.code_op_enabled  = cfg_wdata;
        CFG_CODE_FAULT:       cfg_nxt.code_fault       = cfg_wdata;
        CFG_CODE_ON_DISABLED: cfg_nxt.code_on_disabled = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.status_mask      <= RST_STATUS_MASK;
      cfg_r.code_ready       <= RST_CODE_READY;
      cfg_r.code_switched_on <= RST_CODE_SWITCHED_ON;
      cfg_r.code_op_enabled  <= RST_CODE_OP_ENABLED;
      cfg_r.code_fault       <= RST_CODE_FAULT;
      cfg_r.code_on_disabled <= RST_CODE_ON_DISABLED;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/des_step.sv
// per-event next-state and result logic
module des_step
  import des_pkg::*;
(
  input  cfg_t               cfg,
  input  seq_state_t         state,
  input  logic [2:0]         command,
  input  logic [15:0]        status_in,
  input  logic signed [31:0] position_in,
  input  logic [31:0]        abort_code,
  input  logic signed [31:0] target_in,
  output seq_state_t         state_nxt,
  output result_t            result
);

  logic [15:0] st;
  result_t     res;

  assign st = state.last_status & cfg.status_mask;

  always_comb begin
    state_nxt          = state;
    res.cw_valid       = 1'b0;
    res.control_out    = CW_NONE;
    res.target_valid   = 1'b0;
    res.target_out     = '0;
    res.mode_write_req = 1'b0;
    res.master_mode    = MODE_CODE_IDLE;

    unique case (command)
      CMD_SYNC: begin
        unique case (state.mode)
          MODE_SETUP: begin
            if (!state.write_sent) begin
              res.mode_write_req   = 1'b1;
              state_nxt.write_sent = 1'b1;
            end else if (state.write_done) begin
              state_nxt.write_done = 1'b0;
              state_nxt.write_sent = 1'b0;
              res.cw_valid         = 1'b1;
              res.control_out      = CW_SHUTDOWN;
              state_nxt.mode       = MODE_SHUTDOWN;
            end
          end
          MODE_SHUTDOWN: begin
            if (st == cfg.code_ready) begin
              res.cw_valid    = 1'b1;
              res.control_out = CW_SWITCH_ON;
              state_nxt.mode  = MODE_SWON;
            end
          end
          MODE_SWON: begin
            if (st == cfg.code_switched_on) begin
              state_nxt.held_target = state.last_position;
              res.target_valid      = 1'b1;
              res.target_out        = state.last_position;
              res.cw_valid          = 1'b1;
              res.control_out       = CW_ENABLE_OP;
              state_nxt.mode        = MODE_ENABLE;
            end
          end
          MODE_ENABLE: begin
            if (st == cfg.code_op_enabled) state_nxt.mode = MODE_RUNNING;
          end
          MODE_RUNNING: begin
            res.target_valid = 1'b1;
            res.target_out   = state.held_target;
            if (st == cfg.code_fault) begin
              state_nxt.reset_sent = 1'b0;
              state_nxt.mode       = MODE_FAULT;
            end else if (st == cfg.code_on_disabled || st == cfg.code_ready ||
                         st == cfg.code_switched_on) begin
              state_nxt.mode = MODE_IDLE;
            end
          end
          MODE_FAULT: begin
            res.cw_valid = 1'b1;
            if (!state.reset_sent) begin
              res.control_out      = CW_FAULT_RESET;
              state_nxt.reset_sent = 1'b1;
            end else begin
              res.control_out      = CW_SHUTDOWN;
              state_nxt.reset_sent = 1'b0;
              state_nxt.mode       = MODE_SHUTDOWN;
            end
          end
          default: ;
        endcase
      end
      CMD_STATUS: begin
        state_nxt.last_status   = status_in;
        state_nxt.last_position = position_in;
      end
      CMD_RUNNING: begin
        state_nxt.write_done  = 1'b0;
        state_nxt.write_sent  = 1'b0;
        state_nxt.reset_sent  = 1'b0;
        state_nxt.last_status = '0;
        state_nxt.mode        = MODE_SETUP;
      end
      CMD_STOPPED: begin
        res.cw_valid    = 1'b1;
        res.control_out = CW_QUICK_STOP;
        state_nxt.mode  = MODE_IDLE;
      end
      CMD_CONFIRM: begin
        // nonzero abort code drops back to idle from any mode
        if (abort_code != '0) state_nxt.mode = MODE_IDLE;
        else state_nxt.write_done = 1'b1;
      end
      CMD_TARGET: begin
        state_nxt.held_target = target_in;
        if (state.mode == MODE_RUNNING) begin
          res.target_valid = 1'b1;
          res.target_out   = target_in;
        end
      end
      default: ;
    endcase

    res.master_mode = mode_code(state_nxt.mode);
  end

  assign result = res;

endmodule

// File: src/des_checker.sv
// port-level checks for the drive enable sequencer and their bind
module des_sva
  import des_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_cw_valid,
  input logic [15:0]        out_control_out,
  input logic               out_target_valid,
  input logic signed [31:0] out_target_out,
  input logic               out_mode_write_req,
  input logic [2:0]         out_master_mode
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_control_out) &&
      $stable(out_target_out) && $stable(out_master_mode))
    else $error("stalled result item changed");

  a_cw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cw_valid |-> out_control_out == CW_NONE)
    else $error("control word nonzero without cw_valid");

  a_tgt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_target_valid |-> out_target_out == '0)
    else $error("target nonzero without target_valid");

  // mode write only issued while staying in setup, never with a control word
  a_mw_setup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_write_req |->
      out_master_mode == MODE_CODE_SETUP && !out_cw_valid && !out_target_valid)
    else $error("mode write request outside setup");

  // quick stop always lands in idle
  a_qstop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cw_valid && out_control_out == CW_QUICK_STOP |->
      out_master_mode == MODE_CODE_IDLE)
    else $error("quick stop without idle mode");

endmodule

bind drive_enable_sequencer des_sva u_des_sva (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_cw_valid       (out_cw_valid),
  .out_control_out    (out_control_out),
  .out_target_valid   (out_target_valid),
  .out_target_out     (out_target_out),
  .out_mode_write_req (out_mode_write_req),
  .out_master_mode    (out_master_mode)
);

// File: tb/des_checker.sv
// checker for the drive enable sequencer: tracks the channels, predicts each result and compares
module des_checker
  import des_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [15:0]        in_status_in,
  input  logic signed [31:0] in_position_in,
  input  logic [31:0]        in_abort_code,
  input  logic signed [31:0] in_target_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_cw_valid,
  input  logic [15:0]        out_control_out,
  input  logic               out_target_valid,
  input  logic signed [31:0] out_target_out,
  input  logic               out_mode_write_req,
  input  logic [2:0]         out_master_mode,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata,
  output int                 mismatches,
  output int                 waiting_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // configuration as the block should hold it
  logic [15:0] mask_q, ready_q, swon_q, op_en_q, fault_q, on_dis_q;

  // sequencer state
  logic [2:0]  seq_mode;
  logic        write_sent, write_done, reset_sent;
  logic [15:0] status_q;
  logic [31:0] position_q, target_q;

  result_t expected_results[$];

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] wanted);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
    mismatches++;
  endtask

  function automatic result_t sequence_event(input logic [2:0] cmd, input logic [15:0] status,
                                             input logic [31:0] position,
                                             input logic [31:0] abort,
                                             input logic [31:0] target);
    result_t r;
    logic [15:0] st;
    r = '0;
    st = status_q & mask_q;
    case (cmd)
      CMD_SYNC: begin
        case (seq_mode)
          MODE_CODE_SETUP: begin
            if (!write_sent) begin
              r.mode_write_req = 1'b1;
              write_sent = 1'b1;
            end else if (write_done) begin
              write_done = 1'b0;
              write_sent = 1'b0;
              r.cw_valid = 1'b1;
              r.control_out = CW_SHUTDOWN;
              seq_mode = MODE_CODE_SHUTDOWN;
            end
          end
          MODE_CODE_SHUTDOWN: begin
            if (st == ready_q) begin
              r.cw_valid = 1'b1;
              r.control_out = CW_SWITCH_ON;
              seq_mode = MODE_CODE_SWON;
            end
          end
          MODE_CODE_SWON: begin
            if (st == swon_q) begin
              target_q = position_q;
              r.target_valid = 1'b1;
              r.target_out = target_q;
              r.cw_valid = 1'b1;
              r.control_out = CW_ENABLE_OP;
              seq_mode = MODE_CODE_ENABLE;
            end
          end
          MODE_CODE_ENABLE: begin
            if (st == op_en_q) seq_mode = MODE_CODE_RUNNING;
          end
          MODE_CODE_RUNNING: begin
            r.target_valid = 1'b1;
            r.target_out = target_q;
            if (st == fault_q) begin
              reset_sent = 1'b0;
              seq_mode = MODE_CODE_FAULT;
            end else if (st == on_dis_q || st == ready_q || st == swon_q) begin
              seq_mode = MODE_CODE_IDLE;
            end
          end
          MODE_CODE_FAULT: begin
            r.cw_valid = 1'b1;
            if (!reset_sent) begin
              r.control_out = CW_FAULT_RESET;
              reset_sent = 1'b1;
            end else begin
              r.control_out = CW_SHUTDOWN;
              reset_sent = 1'b0;
              seq_mode = MODE_CODE_SHUTDOWN;
            end
          end
          default: ;
        endcase
      end
      CMD_STATUS: begin
        status_q = status;
        position_q = position;
      end
      CMD_RUNNING: begin
        write_done = 1'b0;
        write_sent = 1'b0;
        reset_sent = 1'b0;
        status_q = '0;
        seq_mode = MODE_CODE_SETUP;
      end
      CMD_STOPPED: begin
        r.cw_valid = 1'b1;
        r.control_out = CW_QUICK_STOP;
        seq_mode = MODE_CODE_IDLE;
      end
      CMD_CONFIRM: begin
        if (abort != 0) seq_mode = MODE_CODE_IDLE;
        else write_done = 1'b1;
      end
      CMD_TARGET: begin
        target_q = target;
        if (seq_mode == MODE_CODE_RUNNING) begin
          r.target_valid = 1'b1;
          r.target_out = target_q;
        end
      end
      default: ;
    endcase
    r.master_mode = seq_mode;
    return r;
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    result_t got, exp;
    if (!rst_n) begin
      mask_q = RST_STATUS_MASK;
      ready_q = RST_CODE_READY;
      swon_q = RST_CODE_SWITCHED_ON;
      op_en_q = RST_CODE_OP_ENABLED;
      fault_q = RST_CODE_FAULT;
      on_dis_q = RST_CODE_ON_DISABLED;
      seq_mode = MODE_CODE_IDLE;
      write_sent = 1'b0;
      write_done = 1'b0;
      reset_sent = 1'b0;
      status_q = '0;
      position_q = '0;
      target_q = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_STATUS_MASK:      mask_q = cfg_wdata;
          CFG_CODE_READY:       ready_q = cfg_wdata;
          CFG_CODE_SWITCHED_ON: swon_q = cfg_wdata;
          CFG_CODE_OP_ENABLED:  op_en_q = cfg_wdata;
          CFG_CODE_FAULT:       fault_q = cfg_wdata;
          CFG_CODE_ON_DISABLED: on_dis_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.cw_valid = out_cw_valid;
        got.control_out = out_control_out;
        got.target_valid = out_target_valid;
        got.target_out = out_target_out;
        got.mode_write_req = out_mode_write_req;
        got.master_mode = out_master_mode;
        if (expected_results.size() == 0) begin
          report("result item with nothing expected", 32'(got.master_mode), 32'd0);
        end else begin
          exp = expected_results.pop_front();
          if (got.cw_valid !== exp.cw_valid)
            report("cw_valid", 32'(got.cw_valid), 32'(exp.cw_valid));
          if (got.control_out !== exp.control_out)
            report("control_out", 32'(got.control_out), 32'(exp.control_out));
          if (got.target_valid !== exp.target_valid)
            report("target_valid", 32'(got.target_valid), 32'(exp.target_valid));
          if (got.target_out !== exp.target_out)
            report("target_out", got.target_out, exp.target_out);
          if (got.mode_write_req !== exp.mode_write_req)
            report("mode_write_req", 32'(got.mode_write_req), 32'(exp.mode_write_req));
          if (got.master_mode !== exp.master_mode)
            report("master_mode", 32'(got.master_mode), 32'(exp.master_mode));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(sequence_event(in_command, in_status_in, in_position_in,
                                                  in_abort_code, in_target_in));
    end
    waiting_results = expected_results.size();
  end

endmodule

// File: tb/tb.sv
// top-level bench for the drive enable sequencer: stimulus, handshake idling and verdict
module tb
  import des_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int NUM_ITEMS   = 850;
  localparam int NUM_PHASES  = 7;
  localparam int SETTLE      = 4;
  localparam int QUIET_LIMIT = 2000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_command;
  logic [15:0]        in_status_in;
  logic signed [31:0] in_position_in;
  logic [31:0]        in_abort_code;
  logic signed [31:0] in_target_in;
  logic               out_valid;
  logic               out_stall;
  logic               out_cw_valid;
  logic [15:0]        out_control_out;
  logic               out_target_valid;
  logic signed [31:0] out_target_out;
  logic               out_mode_write_req;
  logic [2:0]         out_master_mode;
  logic               cfg_we;
  logic [CFG_AW-1:0]  cfg_addr;
  logic [CFG_DW-1:0]  cfg_wdata;
  int                 mismatches;
  int                 waiting_results;

  // register values as last written, used to shape status words
  logic [15:0] reg_val [0:5];
  bit          calm;
  int          items_sent;
  int          quiet;

  drive_enable_sequencer dut (.*);
  des_checker chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[drive_enable_sequencer] ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 4))
      0: return reg_val[CFG_CODE_READY];
      1: return reg_val[CFG_CODE_SWITCHED_ON];
      2: return reg_val[CFG_CODE_OP_ENABLED];
      3: return reg_val[CFG_CODE_FAULT];
      default: return reg_val[CFG_CODE_ON_DISABLED];
    endcase
  endfunction

  function automatic logic [31:0] bad_abort();
    logic [31:0] v;
    v = $urandom;
    if (v == 0) v = 32'd1;
    return v;
  endfunction

  task automatic send(input logic [2:0] c, input logic [15:0] s, input logic [31:0] p,
                      input logic [31:0] a, input logic [31:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_status_in <= s;
    in_position_in <= p;
    in_abort_code <= a;
    in_target_in <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic ev(input logic [2:0] c);
    send(c, 16'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic confirm_ok();
    send(CMD_CONFIRM, 16'($urandom), $urandom, 32'd0, $urandom);
  endtask

  // status frame whose masked word equals the code where the code lies inside the mask
  task automatic frame(input logic [15:0] code, input logic [31:0] pos);
    logic [15:0] noise;
    noise = 16'($urandom);
    send(CMD_STATUS, code | (noise & ~reg_val[CFG_STATUS_MASK]), pos, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting_results != 0);
  endtask

  task automatic put_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    reg_val[idx] = val;
    @(negedge clk);
  endtask

  // bring-up from setup to running, then one of the ways out; a rare failed confirm ends it early
  task automatic bring_up();
    int n;
    ev(CMD_RUNNING);
    if ($urandom_range(0, 3) == 0) frame(pick_code(), $urandom);
    ev(CMD_SYNC);
    if ($urandom_range(0, 3) == 0) ev(CMD_SYNC);
    if ($urandom_range(0, 9) == 0) begin
      send(CMD_CONFIRM, 16'($urandom), $urandom, bad_abort(), $urandom);
      return;
    end
    confirm_ok();
    ev(CMD_SYNC);
    if ($urandom_range(0, 3) == 0) begin
      frame(pick_code(), $urandom);
      ev(CMD_SYNC);
    end
    frame(reg_val[CFG_CODE_READY], $urandom);
    ev(CMD_SYNC);
    frame(reg_val[CFG_CODE_SWITCHED_ON], $urandom);
    ev(CMD_SYNC);
    frame(reg_val[CFG_CODE_OP_ENABLED], $urandom);
    ev(CMD_SYNC);
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: ev(CMD_SYNC);
        1: ev(CMD_TARGET);
        default: frame(reg_val[CFG_CODE_OP_ENABLED], $urandom);
      endcase
    end
    case ($urandom_range(0, 4))
      0: begin
        frame(reg_val[CFG_CODE_FAULT], $urandom);
        repeat (3) ev(CMD_SYNC);
        if ($urandom_range(0, 1) == 0) begin
          frame(reg_val[CFG_CODE_READY], $urandom);
          ev(CMD_SYNC);
        end
      end
      1: begin
        frame(reg_val[CFG_CODE_ON_DISABLED], $urandom);
        ev(CMD_SYNC);
      end
      2: begin
        frame($urandom_range(0, 1) ? reg_val[CFG_CODE_READY] : reg_val[CFG_CODE_SWITCHED_ON],
              $urandom);
        ev(CMD_SYNC);
      end
      3: ev(CMD_STOPPED);
      default: send(CMD_CONFIRM, 16'($urandom), $urandom, bad_abort(), $urandom);
    endcase
  endtask

  // result side: stall for a random gap, possibly none, before taking each item
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int phase_end;
    logic [15:0] noise;
    logic [2:0] c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_SYNC;
    in_status_in = '0;
    in_position_in = '0;
    in_abort_code = '0;
    in_target_in = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_STATUS_MASK;
    cfg_wdata = '0;
    calm = 1'b0;
    items_sent = 0;
    quiet = 0;
    reg_val[CFG_STATUS_MASK] = RST_STATUS_MASK;
    reg_val[CFG_CODE_READY] = RST_CODE_READY;
    reg_val[CFG_CODE_SWITCHED_ON] = RST_CODE_SWITCHED_ON;
    reg_val[CFG_CODE_OP_ENABLED] = RST_CODE_OP_ENABLED;
    reg_val[CFG_CODE_FAULT] = RST_CODE_FAULT;
    reg_val[CFG_CODE_ON_DISABLED] = RST_CODE_ON_DISABLED;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed walk through every mode with the reset configuration
    ev(CMD_SYNC);
    send(CMD_STATUS, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send(CMD_STATUS, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    send(CMD_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_SPARE_7, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    ev(CMD_RUNNING);
    ev(CMD_SYNC);
    ev(CMD_SYNC);
    confirm_ok();
    ev(CMD_SYNC);
    frame(reg_val[CFG_CODE_READY], 32'h8000_0000);
    ev(CMD_SYNC);
    frame(reg_val[CFG_CODE_SWITCHED_ON], 32'h7FFF_FFFF);
    ev(CMD_SYNC);
    frame(reg_val[CFG_CODE_OP_ENABLED], $urandom);
    ev(CMD_SYNC);
    send(CMD_TARGET, 16'($urandom), $urandom, $urandom, 32'h8000_0000);
    frame(reg_val[CFG_CODE_FAULT], $urandom);
    ev(CMD_SYNC);
    ev(CMD_SYNC);
    ev(CMD_SYNC);
    send(CMD_CONFIRM, 16'($urandom), $urandom, 32'hFFFF_FFFF, $urandom);
    send(CMD_TARGET, 16'($urandom), $urandom, $urandom, 32'hFFFF_FFFF);
    ev(CMD_STOPPED);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // the block must be idle before its registers change
      drain();
      repeat (SETTLE) @(negedge clk);
      case (p)
        0: begin
          put_reg(CFG_STATUS_MASK, RST_STATUS_MASK);
          put_reg(CFG_CODE_READY, RST_CODE_READY);
          put_reg(CFG_CODE_SWITCHED_ON, RST_CODE_SWITCHED_ON);
          put_reg(CFG_CODE_OP_ENABLED, RST_CODE_OP_ENABLED);
          put_reg(CFG_CODE_FAULT, RST_CODE_FAULT);
          put_reg(CFG_CODE_ON_DISABLED, RST_CODE_ON_DISABLED);
        end
        1: begin
          put_reg(CFG_STATUS_MASK, 16'hFFFF);
          put_reg(CFG_CODE_READY, 16'($urandom));
          put_reg(CFG_CODE_SWITCHED_ON, 16'($urandom));
          put_reg(CFG_CODE_OP_ENABLED, 16'($urandom));
          put_reg(CFG_CODE_FAULT, 16'($urandom));
          put_reg(CFG_CODE_ON_DISABLED, 16'($urandom));
        end
        2: begin
          // every masked word matches every code
          put_reg(CFG_STATUS_MASK, 16'h0000);
          put_reg(CFG_CODE_READY, 16'h0000);
          put_reg(CFG_CODE_SWITCHED_ON, 16'h0000);
          put_reg(CFG_CODE_OP_ENABLED, 16'h0000);
          put_reg(CFG_CODE_FAULT, 16'h0000);
          put_reg(CFG_CODE_ON_DISABLED, 16'h0000);
        end
        4: begin
          // codes with bits outside the mask never match
          put_reg(CFG_STATUS_MASK, 16'($urandom_range(0, 16'hFFFE)));
          put_reg(CFG_CODE_READY, 16'hFFFF);
          put_reg(CFG_CODE_SWITCHED_ON, 16'hFFFF);
          put_reg(CFG_CODE_OP_ENABLED, 16'hFFFF);
          put_reg(CFG_CODE_FAULT, 16'hFFFF);
          put_reg(CFG_CODE_ON_DISABLED, 16'hFFFF);
        end
        5: begin
          put_reg(CFG_STATUS_MASK, 16'hFFFF);
          put_reg(CFG_CODE_READY, 16'h0000);
          put_reg(CFG_CODE_SWITCHED_ON, 16'hFFFF);
          put_reg(CFG_CODE_OP_ENABLED, 16'($urandom));
          put_reg(CFG_CODE_FAULT, 16'($urandom));
          put_reg(CFG_CODE_ON_DISABLED, 16'hFFFF);
        end
        default: begin
          // random mask with codes inside it
          put_reg(CFG_STATUS_MASK, 16'($urandom));
          put_reg(CFG_CODE_READY, 16'($urandom) & reg_val[CFG_STATUS_MASK]);
          put_reg(CFG_CODE_SWITCHED_ON, 16'($urandom) & reg_val[CFG_STATUS_MASK]);
          put_reg(CFG_CODE_OP_ENABLED, 16'($urandom) & reg_val[CFG_STATUS_MASK]);
          put_reg(CFG_CODE_FAULT, 16'($urandom) & reg_val[CFG_STATUS_MASK]);
          put_reg(CFG_CODE_ON_DISABLED, 16'($urandom) & reg_val[CFG_STATUS_MASK]);
        end
      endcase
      cfg_we <= 1'b0;
      @(negedge clk);

      phase_end = items_sent + NUM_ITEMS / NUM_PHASES;
      while (items_sent < phase_end) begin
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 3) == 0) begin
          // stray item with random command and fields
          c = 3'($urandom_range(0, 7));
          noise = 16'($urandom);
          send(c, $urandom_range(0, 1) ? (pick_code() | (noise & ~reg_val[CFG_STATUS_MASK]))
                                       : noise,
               $urandom, $urandom_range(0, 1) ? 32'd0 : $urandom, $urandom);
        end else begin
          bring_up();
        end
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0)
      $display("[drive_enable_sequencer] OK");
    else
      $display("[drive_enable_sequencer] ERROR");
    $finish;
  end

endmodule

// File: files.f
src/des_pkg.sv
src/des_cfg_regs.sv
src/des_step.sv
src/drive_enable_sequencer.sv
src/des_checker.sv
tb/des_checker.sv
tb/tb.sv
